@@ sv/e8alu_pkg.sv @@
// types, operation codes and field layout shared by the eight-bit alu files
package e8alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_RLC   = 5'd8,
        OP_RRC   = 5'd9,
        OP_RL    = 5'd10,
        OP_RR    = 5'd11,
        OP_SLA   = 5'd12,
        OP_SRA   = 5'd13,
        OP_SRL   = 5'd14,
        OP_SWAP  = 5'd15,
        OP_BIT   = 5'd16,
        OP_RES   = 5'd17,
        OP_SET   = 5'd18,
        OP_CPL   = 5'd19,
        OP_SCF   = 5'd20,
        OP_CCF   = 5'd21,
        OP_ADDHL = 5'd22,
        OP_ADDSP = 5'd23,
        OP_INC16 = 5'd24,
        OP_DEC16 = 5'd25
    } kind_t;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic        acc_form;
        logic [3:0]  flags_in;
        logic [2:0]  bit_index;
        logic [15:0] word_b;
        logic [15:0] word_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_a;
        kind_t       kind;
    } in_item_t;

    typedef struct packed {
        logic        writes_back;
        logic [3:0]  flags_out;
        logic [15:0] result;
    } out_item_t;

    localparam int IN_W  = $bits(in_item_t);
    localparam int OUT_W = $bits(out_item_t);

endpackage

@@ sv/e8alu_stage.sv @@
// one pipeline register with valid bit and ready back-pressure
module e8alu_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/e8alu_core.sv @@
// operation decode, arithmetic and flag generation for one beat
module e8alu_core (
    input  e8alu_pkg::in_item_t  item,
    output e8alu_pkg::out_item_t res
);
    import e8alu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        t;
    logic [8:0]  sum9;
    logic [4:0]  sum5;
    logic [8:0]  dif9;
    logic [4:0]  dif5;
    logic [7:0]  r8;
    logic        rot_c;
    logic [7:0]  bit_mask;
    logic [16:0] hl17;
    logic [12:0] hl13;
    logic [7:0]  off;
    logic [4:0]  sp5;
    logic [8:0]  sp9;
    logic [15:0] sp16;

    always_comb
    begin
        a        = item.byte_a;
        b        = item.byte_b;
        cin      = item.flags_in[FLAG_C];
        t        = ((item.kind == OP_ADC) || (item.kind == OP_SBC)) ? cin : 1'b0;
        sum9     = {1'b0, a} + {1'b0, b} + {8'd0, t};
        sum5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        dif9     = {1'b0, a} - {1'b0, b} - {8'd0, t};
        dif5     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        bit_mask = 8'd1 << item.bit_index;
        hl17     = {1'b0, item.word_a} + {1'b0, item.word_b};
        hl13     = {1'b0, item.word_a[11:0]} + {1'b0, item.word_b[11:0]};
        off      = item.word_b[7:0];
        sp5      = {1'b0, item.word_a[3:0]} + {1'b0, off[3:0]};
        sp9      = {1'b0, item.word_a[7:0]} + {1'b0, off};
        sp16     = item.word_a + {{8{off[7]}}, off};

        unique case (item.kind)
            OP_RLC:  begin rot_c = b[7]; r8 = {b[6:0], b[7]}; end
            OP_RRC:  begin rot_c = b[0]; r8 = {b[0], b[7:1]}; end
            OP_RL:   begin rot_c = b[7]; r8 = {b[6:0], cin};  end
            default: begin rot_c = b[0]; r8 = {cin, b[7:1]};  end
        endcase

        res.result      = 16'd0;
        res.flags_out   = item.flags_in;
        res.writes_back = 1'b1;

        unique case (item.kind)
            OP_ADD, OP_ADC:
            begin
                res.result    = {8'd0, sum9[7:0]};
                res.flags_out = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                res.result      = {8'd0, dif9[7:0]};
                res.flags_out   = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
                res.writes_back = (item.kind != OP_CP);
            end
            OP_AND:
            begin
                res.result    = {8'd0, a & b};
                res.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                res.result    = {8'd0, a ^ b};
                res.flags_out = {(a ^ b) == 8'd0, 3'b000};
            end
            OP_OR:
            begin
                res.result    = {8'd0, a | b};
                res.flags_out = {(a | b) == 8'd0, 3'b000};
            end
            OP_RLC, OP_RRC, OP_RL, OP_RR:
            begin
                res.result    = {8'd0, r8};
                res.flags_out = {!item.acc_form && (r8 == 8'd0), 2'b00, rot_c};
            end
            OP_SLA:
            begin
                res.result    = {8'd0, b[6:0], 1'b0};
                res.flags_out = {b[6:0] == 7'd0, 2'b00, b[7]};
            end
            OP_SRA:
            begin
                res.result    = {8'd0, b[7], b[7:1]};
                res.flags_out = {b[7:1] == 7'd0, 2'b00, b[0]};
            end
            OP_SRL:
            begin
                res.result    = {8'd0, 1'b0, b[7:1]};
                res.flags_out = {b[7:1] == 7'd0, 2'b00, b[0]};
            end
            OP_SWAP:
            begin
                res.result    = {8'd0, b[3:0], b[7:4]};
                res.flags_out = {b == 8'd0, 3'b000};
            end
            OP_BIT:
            begin
                res.result      = {8'd0, b};
                res.flags_out   = {(b & bit_mask) == 8'd0, 1'b0, 1'b1, cin};
                res.writes_back = 1'b0;
            end
            OP_RES:
            begin
                res.result = {8'd0, b & ~bit_mask};
            end
            OP_SET:
            begin
                res.result = {8'd0, b | bit_mask};
            end
            OP_CPL:
            begin
                res.result    = {8'd0, ~a};
                res.flags_out = {item.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF:
            begin
                res.flags_out   = {item.flags_in[FLAG_Z], 3'b001};
                res.writes_back = 1'b0;
            end
            OP_CCF:
            begin
                res.flags_out   = {item.flags_in[FLAG_Z], 2'b00, !cin};
                res.writes_back = 1'b0;
            end
            OP_ADDHL:
            begin
                res.result    = hl17[15:0];
                res.flags_out = {item.flags_in[FLAG_Z], 1'b0, hl13[12], hl17[16]};
            end
            OP_ADDSP:
            begin
                res.result    = sp16;
                res.flags_out = {2'b00, sp5[4], sp9[8]};
            end
            OP_INC16:
            begin
                res.result = item.word_a + 16'd1;
            end
            OP_DEC16:
            begin
                res.result = item.word_a - 16'd1;
            end
            default:
            begin
                // unused codes
                res.writes_back = 1'b0;
            end
        endcase
    end

endmodule

@@ sv/eight_bit_cpu_alu_with_flags.sv @@
// top level of the flag-producing eight-bit alu
//
// channel   dir  beat contents
// s_axis    in   tdata operands and flags, tuser operation code and accumulator form
// m_axis    out  tdata result and new flags, tuser write-back flag
//
// one beat accepted per cycle unless m_axis stalls with both registers full
// input register, then alu logic, then result register
// reset clears both valid bits, payload registers are not reset
// s_axis_tready falls only when both registers hold beats and m_axis stalls
module eight_bit_cpu_alu_with_flags (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // byte_a, byte_b, word_a, word_b, bit_index, flags_in, zero pad
    input  logic [55:0] s_axis_tdata,
    // kind, acc_form
    input  logic [5:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result, flags_out, zero pad
    output logic [23:0] m_axis_tdata,
    // writes_back
    output logic [0:0]  m_axis_tuser
);
    import e8alu_pkg::*;

    in_item_t  in_item;
    in_item_t  op_item;
    out_item_t alu_out;
    out_item_t res_item;
    logic      op_valid;
    logic      op_ready;

    always_comb
    begin
        in_item.kind      = kind_t'(s_axis_tuser[4:0]);
        in_item.acc_form  = s_axis_tuser[5];
        in_item.byte_a    = s_axis_tdata[7:0];
        in_item.byte_b    = s_axis_tdata[15:8];
        in_item.word_a    = s_axis_tdata[31:16];
        in_item.word_b    = s_axis_tdata[47:32];
        in_item.bit_index = s_axis_tdata[50:48];
        in_item.flags_in  = s_axis_tdata[54:51];
    end

    e8alu_stage #(
        .WIDTH (IN_W)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (op_valid),
        .out_ready (op_ready),
        .out_data  (op_item)
    );

    e8alu_core u_core (
        .item (op_item),
        .res  (alu_out)
    );

    e8alu_stage #(
        .WIDTH (OUT_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (op_valid),
        .in_ready  (op_ready),
        .in_data   (alu_out),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_item)
    );

    assign m_axis_tdata = {4'd0, res_item.flags_out, res_item.result};
    assign m_axis_tuser = res_item.writes_back;

endmodule

@@ sv/e8alu_checker.sv @@
// port-level checks for the eight-bit alu, bound to the top level
module e8alu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted beat gave no result two cycles later");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input held off without an output stall");

endmodule

bind eight_bit_cpu_alu_with_flags e8alu_checker u_e8alu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
